>>> design/scfcd_pkg.sv
// shared constants, types and the crc byte fold for the sensor frame checker
package scfcd_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [2:0]  POS_CRC_LO    = 3'd6;
    localparam logic [2:0]  POS_LAST      = 3'd7;
    localparam logic [2:0]  POS_HUM_HI    = 3'd2;
    localparam int          STORED_BYTES  = 5;
    localparam logic [15:0] TEMP_RESET    = 16'd400;
    localparam logic [15:0] HUM_RESET     = 16'd300;

    typedef struct packed {
        logic               last;
        logic               crc_ok;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
    } t_result;

    // reflected crc-16, lsb first, one byte
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> design/scfcd_frame.sv
// frame tracker: byte position, running crc, stored bytes and decoded values
module scfcd_frame (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_frame_start,
    output scfcd_pkg::t_result   o_result
);
    import scfcd_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic [2:0]  r_pos;
    logic [7:0]  r_bytes [STORED_BYTES];
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;

    logic [2:0]  pos;
    logic [15:0] crc_base;
    logic [15:0] rx_crc;
    logic [14:0] mag;
    logic        ok;
    logic        is_last;

    always_comb begin
        pos      = i_frame_start ? 3'd0 : r_pos;
        crc_base = (pos == 3'd0) ? CRC_INIT : r_crc;
        n_crc    = (pos < POS_CRC_LO) ? crc_fold(crc_base, i_rx_byte) : crc_base;
        is_last  = (pos == POS_LAST);
        rx_crc   = {i_rx_byte, r_bytes[4]};
        ok       = (rx_crc == r_crc);
        mag      = {r_bytes[2][6:0], r_bytes[3]};
        n_hum    = r_hum;
        n_temp   = r_temp;
        if (is_last && ok) begin
            n_hum = {r_bytes[0], r_bytes[1]};
            // sign-magnitude to two's complement, negative zero gives zero
            n_temp = r_bytes[2][7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
        end
        o_result.last        = is_last;
        o_result.crc_ok      = ok;
        o_result.temperature = n_temp;
        o_result.humidity    = n_hum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_pos  <= 3'd0;
            r_temp <= TEMP_RESET;
            r_hum  <= HUM_RESET;
        end else if (i_advance) begin
            r_crc  <= n_crc;
            r_pos  <= pos + 3'd1;
            r_temp <= n_temp;
            r_hum  <= n_hum;
        end
    end

    // bytes 2..6 of the frame, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_advance && pos >= POS_HUM_HI && pos <= POS_CRC_LO) begin
            r_bytes[3'(pos - POS_HUM_HI)] <= i_rx_byte;
        end
    end

endmodule

>>> design/sensor_frame_crc_check_decode.sv
// top level of the sensor reply frame crc checker and decoder
//
// input channel: one beat per frame byte (i_rx_byte, i_frame_start), with
// i_valid/o_ready. i_frame_start marks byte 0 and restarts the crc; without
// it the byte count just advances and wraps after byte 7.
// output channel: one beat per frame, produced by byte 7, carrying the crc
// match flag and the last good humidity and temperature in tenths, with
// o_valid/i_ready.
// an accepted byte waits in the input register and is folded as it leaves;
// the result of byte 7 is loaded into the result register as it leaves.
// throughput: one byte per cycle unless byte 7 waits on a stalled receiver;
// the crc fold, compare and decode all sit between these two registers.
// a stalled receiver holds the result register; bytes that make no result
// keep moving, and byte 7 of the next frame waits in the input register
// until the result register frees up.
// reset clears the byte count, loads the crc seed, sets 40.0 degrees and
// 30.0 percent as last good values and empties both registers.
module sensor_frame_crc_check_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_frame_start,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_crc_ok,
    output logic signed [15:0]  o_temperature_tenths,
    output logic [15:0]         o_humidity_tenths
);
    import scfcd_pkg::*;

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_start;
    logic               r_out_valid;
    logic               r_crc_ok;
    logic signed [15:0] r_temp;
    logic [15:0]        r_hum;

    t_result result;
    logic    advance;

    scfcd_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_rx_byte     (r_in_byte),
        .i_frame_start (r_in_start),
        .o_result      (result)
    );

    assign advance = r_in_valid && (!result.last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte  <= i_rx_byte;
            r_in_start <= i_frame_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && result.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.last) begin
            r_crc_ok <= result.crc_ok;
            r_temp   <= result.temperature;
            r_hum    <= result.humidity;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_crc_ok             = r_crc_ok;
    assign o_temperature_tenths = r_temp;
    assign o_humidity_tenths    = r_hum;

endmodule
